[hw/rtl/lrt_pkg.sv]
// lrt_pkg: shared types and constants for the lru replacement tracker
// used by lrt_cell, lrt_ctrl and lru_replacement_tracker; depends on nothing
`default_nettype none

package lrt_pkg;

  // default set size and fixed field widths
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_WIDTH    = 32;
  localparam int OCC_W        = 5;

  typedef logic [KEY_WIDTH-1:0] key_t;

  // operation codes on the input channel
  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_VICTIM = 2'd1,
    OP_ERASE  = 2'd2
  } op_t;

  // status codes on the result channel
  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  // what a wave does as it walks down the cells
  typedef enum logic [1:0] {
    WAVE_PROBE  = 2'd0,
    WAVE_TOUCH  = 2'd1,
    WAVE_VICTIM = 2'd2,
    WAVE_ERASE  = 2'd3
  } wave_mode_t;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_WAVE = 2'd1,
    CTL_HOLD = 2'd2
  } ctl_state_t;

  // input transfer
  typedef struct packed {
    logic [1:0] operation;
    key_t       key;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic [1:0]       status;
    key_t             victim_key;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // token handed from cell to cell
  typedef struct packed {
    logic       active;
    wave_mode_t mode;
    logic       done;
    logic       found;
    key_t       search_key;
    key_t       carry_key;
  } wave_t;

endpackage

`default_nettype wire

[hw/rtl/lrt_cell.sv]
// lrt_cell: one slot of the recency chain, holding a key and its valid bit
// depends on lrt_pkg (key_t, wave_t, wave_mode_t)
`default_nettype none

module lrt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lrt_pkg::wave_t tok_in,
  input  wire lrt_pkg::key_t next_key,
  input  wire logic          next_valid,
  output lrt_pkg::wave_t     tok_out,
  output lrt_pkg::key_t      key_out,
  output logic               valid_out
);

  lrt_pkg::key_t  key_r, key_nxt;
  logic           valid_r, valid_nxt;
  lrt_pkg::wave_t tok_r, tok_nxt;
  logic           hit;

  assign hit = valid_r && (key_r == tok_in.search_key);

  // act on the token as it passes this slot
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    tok_nxt   = tok_in;
    if (tok_in.active) begin
      case (tok_in.mode)
        lrt_pkg::WAVE_PROBE: begin
          if (hit) begin
            tok_nxt.found = 1'b1;
          end
        end
        lrt_pkg::WAVE_TOUCH: begin
          if (!tok_in.done) begin
            key_nxt = tok_in.carry_key;
            if (hit) begin
              // key met again: the displaced key fills its old slot
              tok_nxt.done  = 1'b1;
              tok_nxt.found = 1'b1;
            end else if (!valid_r) begin
              // first free slot takes the displaced key
              valid_nxt    = 1'b1;
              tok_nxt.done = 1'b1;
            end else begin
              tok_nxt.carry_key = key_r;
            end
          end
        end
        lrt_pkg::WAVE_ERASE: begin
          // from the erased slot on, pull the neighbour one place forward
          if (valid_r && (hit || tok_in.found)) begin
            tok_nxt.found = 1'b1;
            key_nxt       = next_key;
            valid_nxt     = next_valid;
          end
        end
        lrt_pkg::WAVE_VICTIM: begin
          // the last valid slot gives up its key
          if (valid_r && !next_valid) begin
            tok_nxt.found     = 1'b1;
            tok_nxt.carry_key = key_r;
            valid_nxt         = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot key, no reset needed
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // valid bit and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign key_out   = key_r;
  assign valid_out = valid_r;

endmodule

`default_nettype wire

[hw/rtl/lrt_ctrl.sv]
// lrt_ctrl: channel handshakes, wave launch, occupancy count and result register
// depends on lrt_pkg (item structs, wave_t, codes, state enum)
`default_nettype none

module lrt_ctrl #(
  parameter int CAPACITY = lrt_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lrt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lrt_pkg::out_item_t      out_data,
  output lrt_pkg::wave_t          launch,
  input  wire lrt_pkg::wave_t     tail
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  lrt_pkg::ctl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  lrt_pkg::wave_t      launch_r, launch_nxt;
  lrt_pkg::out_item_t  pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  lrt_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                full;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign in_stall = (state_r != lrt_pkg::CTL_IDLE);

  // next state, wave launch and result building
  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    launch_nxt        = launch_r;
    launch_nxt.active = 1'b0;
    pend_nxt          = pend_r;
    out_valid_nxt     = out_valid_r;
    out_data_nxt      = out_data_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lrt_pkg::CTL_IDLE: begin
        if (in_valid) begin
          launch_nxt.active     = 1'b1;
          launch_nxt.done       = 1'b0;
          launch_nxt.found      = 1'b0;
          launch_nxt.search_key = in_data.key;
          launch_nxt.carry_key  = in_data.key;
          launch_nxt.mode       = lrt_pkg::WAVE_TOUCH;
          pend_nxt.status       = lrt_pkg::STATUS_DONE;
          pend_nxt.victim_key   = '0;
          pend_nxt.occupancy    = lrt_pkg::OCC_W'(count_r);
          state_nxt             = lrt_pkg::CTL_WAVE;
          case (in_data.operation)
            lrt_pkg::OP_TOUCH: begin
              // a full set needs a read-only pass before anything moves
              if (full) begin
                launch_nxt.mode = lrt_pkg::WAVE_PROBE;
              end
            end
            lrt_pkg::OP_VICTIM: begin
              if (count_r == '0) begin
                launch_nxt.active = 1'b0;
                pend_nxt.status   = lrt_pkg::STATUS_ABSENT;
                state_nxt         = lrt_pkg::CTL_HOLD;
              end else begin
                launch_nxt.mode = lrt_pkg::WAVE_VICTIM;
              end
            end
            lrt_pkg::OP_ERASE: begin
              launch_nxt.mode = lrt_pkg::WAVE_ERASE;
            end
            default: begin
              // unused code: no change, plain done result
              launch_nxt.active = 1'b0;
              state_nxt         = lrt_pkg::CTL_HOLD;
            end
          endcase
        end
      end

      lrt_pkg::CTL_WAVE: begin
        if (tail.active) begin
          pend_nxt.status     = lrt_pkg::STATUS_DONE;
          pend_nxt.victim_key = '0;
          state_nxt           = lrt_pkg::CTL_HOLD;
          case (tail.mode)
            lrt_pkg::WAVE_PROBE: begin
              if (tail.found) begin
                // present key: run the real move to front
                launch_nxt           = tail;
                launch_nxt.mode      = lrt_pkg::WAVE_TOUCH;
                launch_nxt.done      = 1'b0;
                launch_nxt.found     = 1'b0;
                launch_nxt.carry_key = tail.search_key;
                state_nxt            = lrt_pkg::CTL_WAVE;
              end else begin
                pend_nxt.status = lrt_pkg::STATUS_FULL;
              end
            end
            lrt_pkg::WAVE_TOUCH: begin
              if (!tail.found) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            lrt_pkg::WAVE_VICTIM: begin
              if (tail.found) begin
                count_nxt           = count_r - CNT_W'(1);
                pend_nxt.victim_key = tail.carry_key;
              end else begin
                pend_nxt.status = lrt_pkg::STATUS_ABSENT;
              end
            end
            lrt_pkg::WAVE_ERASE: begin
              if (tail.found) begin
                count_nxt = count_r - CNT_W'(1);
              end else begin
                pend_nxt.status = lrt_pkg::STATUS_ABSENT;
              end
            end
            default: begin
            end
          endcase
          pend_nxt.occupancy = lrt_pkg::OCC_W'(count_nxt);
        end
      end

      lrt_pkg::CTL_HOLD: begin
        // move the finished result into the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lrt_pkg::CTL_IDLE;
        end
      end

      default: begin
        state_nxt = lrt_pkg::CTL_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrt_pkg::CTL_IDLE;
      count_r     <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign launch    = launch_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // occupancy never exceeds the set size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // a wave only leaves the chain while the controller waits for it
  a_tail_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
    tail.active |-> (state_r == lrt_pkg::CTL_WAVE))
    else $error("wave finished outside wave state");

  // each launch is a single token
  a_launch_single: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r.active |=> !launch_r.active)
    else $error("launch token held for two cycles");

  // no new transfer accepted while a wave is in the chain
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (launch_r.active || tail.active) |-> in_stall)
    else $error("input accepted during a wave");
`endif

endmodule

`default_nettype wire

[hw/rtl/lru_replacement_tracker.sv]
// lru_replacement_tracker: top level, a chain of CAPACITY slot cells and a controller
// depends on lrt_pkg, lrt_cell and lrt_ctrl
`default_nettype none

// Keeps up to CAPACITY distinct keys in recency order, most recent in cell 0.
// Touch, victim and erase each send a token down the chain of cells, one cell
// per clock; no new input transfer is taken until the result is built, so the
// wait is set by the length of the chain. A touch of a key on a full set first
// runs a read-only pass to see whether the key is held, and sends a second
// token to move it only if it is. Victim on an empty set and the unused
// operation code send no token. A touch of a new key on a full set returns the
// full status and changes nothing. The result sits in an output register, so
// the next item can be taken while it waits downstream.
module lru_replacement_tracker #(
  parameter int CAPACITY = lrt_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lrt_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lrt_pkg::out_item_t     out_data
);

  lrt_pkg::wave_t tok [CAPACITY+1];
  lrt_pkg::key_t  cell_key [CAPACITY];
  logic           cell_valid [CAPACITY];

  lrt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .launch    (tok[0]),
    .tail      (tok[CAPACITY])
  );

  // chain of slots, token passing from cell i to cell i+1
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lrt_pkg::key_t nk;
    logic          nv;
    if (i == CAPACITY - 1) begin : g_last
      assign nk = cell_key[i];
      assign nv = 1'b0;
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign nv = cell_valid[i+1];
    end
    lrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_in     (tok[i]),
      .next_key   (nk),
      .next_valid (nv),
      .tok_out    (tok[i+1]),
      .key_out    (cell_key[i]),
      .valid_out  (cell_valid[i])
    );
  end

endmodule

`default_nettype wire
